FILE: rtl/core/lsl_pkg.sv
package lsl_pkg;

	localparam int DICT_ENTRIES = 256;
	localparam int MAX_WORD     = 24;
	localparam int WIN_SIZE     = MAX_WORD + 1;

	localparam int IDX_W = $clog2(DICT_ENTRIES);
	localparam int CA_W  = $clog2(DICT_ENTRIES * MAX_WORD);
	localparam int WI_W  = $clog2(WIN_SIZE);
	localparam int FW    = $clog2(WIN_SIZE + 1);

	localparam logic [3:0] ST_PLAIN  = 4'd0;
	localparam logic [3:0] ST_LINE   = 4'd1;
	localparam logic [3:0] ST_BLOCK  = 4'd2;
	localparam logic [3:0] ST_NUMBER = 4'd5;
	localparam logic [3:0] ST_SINGLE = 4'd7;
	localparam logic [3:0] ST_DOUBLE = 4'd8;
	localparam logic [3:0] ST_BRACE  = 4'd9;
	localparam logic [3:0] ST_MAX    = 4'd9;
	localparam logic [3:0] CTX_IDENT = 4'd10;

	localparam logic [7:0] CH_DQUOTE  = 8'h22;
	localparam logic [7:0] CH_SQUOTE  = 8'h27;
	localparam logic [7:0] CH_DASH    = 8'h2D;
	localparam logic [7:0] CH_LBRACK  = 8'h5B;
	localparam logic [7:0] CH_RBRACK  = 8'h5D;
	localparam logic [7:0] CH_LBRACE  = 8'h7B;
	localparam logic [7:0] CH_RBRACE  = 8'h7D;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_UNDER   = 8'h5F;
	localparam logic [7:0] CH_DOT     = 8'h2E;
	localparam logic [7:0] CH_LOW_E   = 8'h65;
	localparam logic [7:0] CH_UP_E    = 8'h45;

	typedef struct packed {
		logic             is_text;
		logic             first;
		logic             last;
		logic [7:0]       ch;
		logic [3:0]       sctx;
		logic             dict_ok;
		logic [IDX_W-1:0] slot;
		logic [CA_W-1:0]  caddr;
		logic [4:0]       len;
		logic [3:0]       cls;
	} item_t;

	function automatic logic is_digit(input logic [7:0] c);
		return c inside {[8'h30:8'h39]};
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return c inside {[8'h61:8'h7A], [8'h41:8'h5A]};
	endfunction

	function automatic logic is_ident(input logic [7:0] c);
		return is_alpha(c) || is_digit(c) || c == CH_UNDER;
	endfunction

endpackage

FILE: rtl/core/lsl_front.sv
module lsl_front import lsl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic       kind,
	input  logic [7:0] char_value,
	input  logic       first_of_range,
	input  logic       last_of_range,
	input  logic [3:0] start_context,
	input  logic [7:0] entry_index,
	input  logic [4:0] entry_pos,
	input  logic [4:0] entry_length,
	input  logic [3:0] entry_class,
	output logic       q_valid,
	output item_t      q_item,
	input  logic       q_take
);

	item_t      buf_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	item_t      cls_item;
	logic       do_push;

	// Classify the word before it enters the queue.
	always_comb begin
		cls_item.is_text = kind;
		cls_item.first   = first_of_range;
		cls_item.last    = last_of_range;
		cls_item.ch      = char_value;
		cls_item.sctx    = (start_context == ST_BLOCK || start_context == ST_SINGLE ||
		                    start_context == ST_DOUBLE) ? start_context : ST_PLAIN;
		cls_item.dict_ok = (32'(entry_index) < DICT_ENTRIES) && (32'(entry_pos) < MAX_WORD);
		cls_item.slot    = IDX_W'(entry_index);
		cls_item.caddr   = CA_W'(32'(entry_index) * MAX_WORD + 32'(entry_pos));
		cls_item.len     = entry_length;
		cls_item.cls     = entry_class;
	end

	assign full    = cnt_q == 2'd2;
	assign q_valid = cnt_q != 2'd0;
	assign q_item  = buf_q[rp_q];
	assign do_push = push && !full;

	always_ff @(posedge clk) begin
		if (do_push) begin
			buf_q[wp_q] <= cls_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wp_q <= !wp_q;
			end
			if (q_take && q_valid) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + 2'(do_push) - 2'(q_take && q_valid);
		end
	end

endmodule

FILE: rtl/core/lsl_back.sv
module lsl_back import lsl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  item_t      q_item,
	output logic       q_take,
	output logic       empty,
	input  logic       pop,
	output logic [3:0] style,
	output logic       last_of_run
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECIDE = 3'd1;
	localparam logic [2:0] S_LREQ   = 3'd2;
	localparam logic [2:0] S_LCHK   = 3'd3;
	localparam logic [2:0] S_CREQ   = 3'd4;
	localparam logic [2:0] S_CCHK   = 3'd5;
	localparam logic [2:0] S_EMIT   = 3'd6;

	logic [2:0]       state_q;
	logic [7:0]       wc_mem [DICT_ENTRIES*MAX_WORD];
	logic [8:0]       lc_mem [DICT_ENTRIES];
	logic             lv_q [DICT_ENTRIES];
	logic [7:0]       wc_rd_q;
	logic [8:0]       lc_rd_q;
	logic             lv_rd_q;

	logic [7:0]       win_q [WIN_SIZE];
	logic [FW-1:0]    fill_q;
	logic [3:0]       ctx_q;
	logic [4:0]       run_q;
	logic [3:0]       rs_q;
	logic             flush_q;
	logic [3:0]       sty_q;

	logic [IDX_W-1:0] wi_q;
	logic [CA_W-1:0]  base_q;
	logic [4:0]       k_q;
	logic [4:0]       len_q;
	logic [3:0]       cls_q;

	logic [3:0]       oq_sty_q [2];
	logic             oq_last_q [2];
	logic             owp_q, orp_q;
	logic [1:0]       ocnt_q;
	logic             oq_full, oq_push, oq_pop;

	// Decision for the oldest window character.
	logic [7:0] c0, c1, c2, c3;
	logic       two;
	logic [3:0] d_style, d_ctx, d_rs;
	logic [4:0] d_run;
	logic       d_search, fall;

	logic [4:0] e_len;
	logic [3:0] e_cls;
	logic [4:0] widx;
	logic [7:0] wsel;
	logic       last_word;
	logic [FW-1:0] fb;

	assign c0  = win_q[0];
	assign c1  = win_q[1];
	assign c2  = win_q[2];
	assign c3  = win_q[3];
	assign two = fill_q >= FW'(2);

	always_comb begin
		d_style  = ST_PLAIN;
		d_ctx    = ctx_q;
		d_run    = run_q;
		d_rs     = rs_q;
		d_search = 1'b0;
		fall     = 1'b0;
		if (run_q != 5'd0) begin
			d_run   = run_q - 5'd1;
			d_style = rs_q;
		end else begin
			case (ctx_q)
				ST_SINGLE, ST_DOUBLE: begin
					d_style = ctx_q;
					if (c0 == ((ctx_q == ST_DOUBLE) ? CH_DQUOTE : CH_SQUOTE)) begin
						d_ctx = ST_PLAIN;
					end
				end
				ST_BLOCK: begin
					d_style = ST_BLOCK;
					if (c0 == CH_RBRACK && two && c1 == CH_RBRACK) begin
						d_run = 5'd1;
						d_rs  = ST_BLOCK;
						d_ctx = ST_PLAIN;
					end
				end
				ST_LINE: begin
					if (c0 != CH_NEWLINE) d_style = ST_LINE;
					else fall = 1'b1;
				end
				ST_NUMBER: begin
					if (is_digit(c0) || c0 == CH_DOT || c0 == CH_LOW_E || c0 == CH_UP_E)
						d_style = ST_NUMBER;
					else fall = 1'b1;
				end
				CTX_IDENT: begin
					if (is_ident(c0)) d_style = ST_PLAIN;
					else fall = 1'b1;
				end
				default: fall = 1'b1;
			endcase
			if (fall) begin
				d_ctx = ST_PLAIN;
				if (c0 == CH_DQUOTE) begin
					d_ctx   = ST_DOUBLE;
					d_style = ST_DOUBLE;
				end else if (c0 == CH_SQUOTE) begin
					d_ctx   = ST_SINGLE;
					d_style = ST_SINGLE;
				end else if (fill_q >= FW'(4) && c0 == CH_DASH && c1 == CH_DASH &&
				             c2 == CH_LBRACK && c3 == CH_LBRACK) begin
					d_ctx   = ST_BLOCK;
					d_run   = 5'd3;
					d_rs    = ST_BLOCK;
					d_style = ST_BLOCK;
				end else if (is_digit(c0)) begin
					d_ctx   = ST_NUMBER;
					d_style = ST_NUMBER;
				end else if (is_alpha(c0) || c0 == CH_UNDER) begin
					d_search = 1'b1;
				end else if (two && c0 == CH_DASH && c1 == CH_DASH) begin
					d_ctx   = ST_LINE;
					d_run   = 5'd1;
					d_rs    = ST_LINE;
					d_style = ST_LINE;
				end else if (c0 == CH_LBRACE || c0 == CH_RBRACE) begin
					d_style = ST_BRACE;
				end
			end
		end
	end

	assign e_len     = lv_rd_q ? lc_rd_q[8:4] : 5'd0;
	assign e_cls     = lc_rd_q[3:0];
	assign widx      = (state_q == S_LCHK) ? e_len : k_q;
	assign wsel      = win_q[WI_W'(widx)];
	assign last_word = 32'(wi_q) == DICT_ENTRIES - 1;
	assign fb        = q_item.first ? FW'(0) : fill_q;
	assign q_take    = state_q == S_IDLE && q_valid;

	// Dictionary stores, registered reads.
	always_ff @(posedge clk) begin
		if (q_take && !q_item.is_text && q_item.dict_ok) begin
			wc_mem[q_item.caddr] <= q_item.ch;
			lc_mem[q_item.slot]  <= {q_item.len, q_item.cls};
		end
		wc_rd_q <= wc_mem[CA_W'(base_q + CA_W'(k_q))];
		lc_rd_q <= lc_mem[wi_q];
		lv_rd_q <= lv_q[wi_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DICT_ENTRIES; i++) lv_q[i] <= 1'b0;
		end else if (q_take && !q_item.is_text && q_item.dict_ok) begin
			lv_q[q_item.slot] <= 1'b1;
		end
	end

	// Character window: append at the fill point, shift on each emitted word.
	always_ff @(posedge clk) begin
		if (q_take && q_item.is_text) begin
			win_q[WI_W'(fb)] <= q_item.ch;
		end else if (state_q == S_EMIT && !oq_full) begin
			for (int i = 0; i < WIN_SIZE - 1; i++) win_q[i] <= win_q[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q  <= '0;
			ctx_q   <= ST_PLAIN;
			run_q   <= 5'd0;
			rs_q    <= ST_PLAIN;
			flush_q <= 1'b0;
			sty_q   <= ST_PLAIN;
			wi_q    <= '0;
			base_q  <= '0;
			k_q     <= 5'd0;
			len_q   <= 5'd0;
			cls_q   <= ST_PLAIN;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (q_take && q_item.is_text) begin
						if (q_item.first) begin
							ctx_q <= q_item.sctx;
							run_q <= 5'd0;
							rs_q  <= ST_PLAIN;
						end
						fill_q  <= fb + FW'(1);
						flush_q <= q_item.last;
						if (q_item.last || 32'(fb) + 1 > MAX_WORD) begin
							state_q <= S_DECIDE;
						end
					end
				end
				S_DECIDE: begin
					ctx_q <= d_ctx;
					run_q <= d_run;
					rs_q  <= d_rs;
					sty_q <= d_style;
					if (d_search) begin
						wi_q    <= '0;
						base_q  <= '0;
						k_q     <= 5'd0;
						state_q <= S_LREQ;
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_LREQ: state_q <= S_LCHK;
				S_LCHK: begin
					len_q <= e_len;
					cls_q <= (e_cls <= ST_MAX) ? e_cls : ST_PLAIN;
					k_q   <= 5'd0;
					if (e_len == 5'd0) begin
						ctx_q   <= CTX_IDENT;
						sty_q   <= ST_PLAIN;
						state_q <= S_EMIT;
					end else if (32'(e_len) > MAX_WORD || 6'(e_len) > 6'(fill_q) ||
					             (6'(e_len) < 6'(fill_q) && is_ident(wsel))) begin
						if (last_word) begin
							ctx_q   <= CTX_IDENT;
							sty_q   <= ST_PLAIN;
							state_q <= S_EMIT;
						end else begin
							wi_q    <= wi_q + IDX_W'(1);
							base_q  <= CA_W'(32'(base_q) + MAX_WORD);
							state_q <= S_LREQ;
						end
					end else begin
						state_q <= S_CREQ;
					end
				end
				S_CREQ: state_q <= S_CCHK;
				S_CCHK: begin
					if (wc_rd_q != wsel) begin
						k_q <= 5'd0;
						if (last_word) begin
							ctx_q   <= CTX_IDENT;
							sty_q   <= ST_PLAIN;
							state_q <= S_EMIT;
						end else begin
							wi_q    <= wi_q + IDX_W'(1);
							base_q  <= CA_W'(32'(base_q) + MAX_WORD);
							state_q <= S_LREQ;
						end
					end else if (k_q == len_q - 5'd1) begin
						run_q   <= len_q - 5'd1;
						rs_q    <= cls_q;
						sty_q   <= cls_q;
						state_q <= S_EMIT;
					end else begin
						k_q     <= k_q + 5'd1;
						state_q <= S_CREQ;
					end
				end
				S_EMIT: begin
					if (!oq_full) begin
						fill_q  <= fill_q - FW'(1);
						state_q <= (flush_q && fill_q != FW'(1)) ? S_DECIDE : S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Result queue: a finished word waits here while the sequencer moves on.
	assign oq_full     = ocnt_q == 2'd2;
	assign oq_push     = state_q == S_EMIT && !oq_full;
	assign oq_pop      = pop && !empty;
	assign empty       = ocnt_q == 2'd0;
	assign style       = oq_sty_q[orp_q];
	assign last_of_run = oq_last_q[orp_q];

	always_ff @(posedge clk) begin
		if (oq_push) begin
			oq_sty_q[owp_q]  <= sty_q;
			oq_last_q[owp_q] <= flush_q && fill_q == FW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owp_q  <= 1'b0;
			orp_q  <= 1'b0;
			ocnt_q <= 2'd0;
		end else begin
			if (oq_push) owp_q <= !owp_q;
			if (oq_pop) orp_q <= !orp_q;
			ocnt_q <= ocnt_q + 2'(oq_push) - 2'(oq_pop);
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(fill_q) <= WIN_SIZE) else $error("window overfilled");
	a_emit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT |-> fill_q != FW'(0)) else $error("emit from empty window");
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		q_take |-> state_q == S_IDLE) else $error("item taken while busy");
	a_run_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(run_q) < MAX_WORD) else $error("run count out of range");
	a_oq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ocnt_q != 2'd3) else $error("result queue overflow");

endmodule

FILE: rtl/core/lua_syntax_style_lexer.sv
// An accepted item waits in the input queue until the sequencer is idle. A text word that
// releases a style passes decide and emit, plus a lookup request and check per slot tried
// and a compare request and check per character compared in an identifier search.
// Throughput: one word per cycle when no style is released; otherwise no word is taken until
// emit; a flush repeats decide and emit per word; emit stalls while the result queue is full.
// Reset (arst_n low) empties both queues, the window and the dictionary length table.
module lua_syntax_style_lexer import lsl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic       kind,
	input  logic [7:0] char_value,
	input  logic       first_of_range,
	input  logic       last_of_range,
	input  logic [3:0] start_context,
	input  logic [7:0] entry_index,
	input  logic [4:0] entry_pos,
	input  logic [4:0] entry_length,
	input  logic [3:0] entry_class,
	output logic       empty,
	input  logic       pop,
	output logic [3:0] style,
	output logic       last_of_run
);

	logic  q_valid, q_take;
	item_t q_item;

	lsl_front u_front (
		.clk, .arst_n, .push, .full, .kind, .char_value, .first_of_range,
		.last_of_range, .start_context, .entry_index, .entry_pos, .entry_length,
		.entry_class, .q_valid, .q_item, .q_take
	);

	lsl_back u_back (
		.clk, .arst_n, .q_valid, .q_item, .q_take, .empty, .pop, .style, .last_of_run
	);

endmodule
